// File: sv/sird_pkg.sv
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the radix digit converter.
package sird_pkg;

  // Largest base the alphabet may describe
  localparam int unsigned MaxBase = 16;

  // Number, alphabet and character widths
  localparam int unsigned NumW     = 32;
  localparam int unsigned LenW     = 5;
  localparam int unsigned SymW     = 8;
  localparam int unsigned SymRegW  = 64;
  localparam int unsigned SymCount = 16;
  localparam int unsigned DigitW   = 4;

  // Digit stack: one entry per binary digit at most
  localparam int unsigned StackDepth = NumW;
  localparam int unsigned StackIdxW  = $clog2(StackDepth);
  localparam int unsigned StackCntW  = StackIdxW + 1;

  // Shared divider: quotient bits resolved per cycle
  localparam int unsigned DivBitsPerCycle = 8;
  localparam int unsigned DivSteps        = NumW / DivBitsPerCycle;
  localparam int unsigned DivStepW        = $clog2(DivSteps);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgAlphabetLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSymbolsLow     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSymbolsHigh    = 2'd2;

  // Special characters
  localparam logic [SymW-1:0] SignChar = 8'h2D;
  localparam logic [SymW-1:0] PlusChar = 8'h2B;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture sign and magnitude of a new number
    logic div_step;    // run one divider step
    logic push;        // last divider cycle: push remainder as a digit
    logic emit_sign;   // place '-' in the output register
    logic emit_digit;  // pop a digit into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic quot_zero;   // quotient after this divider cycle is zero
    logic stack_fill;  // this push fills the digit stack
    logic last_digit;  // one digit left on the stack
    logic neg;         // current number is negative
    logic out_free;    // output register can take a character this cycle
  } sts_t;

endpackage

// File: sv/sird_alpha.sv
`timescale 1ns / 1ps
// Alphabet checker: length range, forbidden symbols and repeats.
module sird_alpha (
  input  logic [sird_pkg::LenW-1:0]      len_i,
  input  logic [2*sird_pkg::SymRegW-1:0] symbols_i,
  output logic                           ok_o
);
  import sird_pkg::*;

  logic [SymW-1:0] sym [SymCount];
  logic            bad;

  // Split the symbol registers into bytes
  always_comb begin
    for (int i = 0; i < SymCount; i++) begin
      sym[i] = symbols_i[i*SymW +: SymW];
    end
  end

  // Flag a forbidden symbol or a repeat among the symbols in use
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < SymCount; i++) begin
      if (LenW'(i) < len_i) begin
        if (sym[i] == '0 || sym[i] == PlusChar || sym[i] == SignChar) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < SymCount; j++) begin
          if (LenW'(j) < len_i && sym[j] == sym[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign ok_o = !bad && (len_i >= LenW'(2)) && (len_i <= LenW'(MaxBase));

endmodule

// File: sv/sird_dp.sv
`timescale 1ns / 1ps
// Datapath: magnitude divider, digit stack, symbol lookup and output register.
module sird_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sird_pkg::NumW-1:0]      number_i,
  input  logic [sird_pkg::LenW-1:0]      base_i,
  input  logic [2*sird_pkg::SymRegW-1:0] symbols_i,
  input  sird_pkg::cmd_t                 cmd_i,
  output sird_pkg::sts_t                 sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [sird_pkg::SymW-1:0]      character_o,
  output logic                           last_o
);
  import sird_pkg::*;

  logic [NumW-1:0]      mag_q;
  logic [DigitW-1:0]    rem_q;
  logic                 neg_q;
  logic [StackCntW-1:0] nd_q;
  logic [DigitW-1:0]    stack_q [StackDepth];
  logic [SymW-1:0]      char_q;
  logic                 last_q;
  logic                 out_valid_q;

  logic [NumW-1:0]      quo_nxt;
  logic [LenW-1:0]      rem_nxt;
  logic [StackIdxW-1:0] top_idx;
  logic [DigitW-1:0]    top_digit;
  logic [SymW-1:0]      top_sym;
  logic                 out_free;

  // Resolve DivBitsPerCycle quotient bits by shift and subtract
  always_comb begin
    logic [LenW-1:0] r;
    logic [NumW-1:0] q;
    r = LenW'(rem_q);
    q = mag_q;
    for (int k = 0; k < DivBitsPerCycle; k++) begin
      r = {r[LenW-2:0], q[NumW-1]};
      q = {q[NumW-2:0], 1'b0};
      if (r >= base_i) begin
        r    = r - base_i;
        q[0] = 1'b1;
      end
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  // Look up the symbol for the digit on top of the stack
  assign top_idx   = StackIdxW'(nd_q - StackCntW'(1));
  assign top_digit = stack_q[top_idx];
  assign top_sym   = symbols_i[top_digit*SymW +: SymW];

  assign out_free = !out_valid_q || out_ready_i;

  // Hold control state: sign, divider operands, stack depth, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        neg_q <= number_i[NumW-1];
        mag_q <= number_i[NumW-1] ? (NumW'(0) - number_i) : number_i;
        rem_q <= '0;
        nd_q  <= '0;
      end else if (cmd_i.div_step) begin
        mag_q <= quo_nxt;
        rem_q <= cmd_i.push ? '0 : rem_nxt[DigitW-1:0];
        if (cmd_i.push) begin
          nd_q <= nd_q + StackCntW'(1);
        end
      end else if (cmd_i.emit_digit) begin
        nd_q <= nd_q - StackCntW'(1);
      end
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Push the remainder of a finished division
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && cmd_i.push) begin
      stack_q[nd_q[StackIdxW-1:0]] <= rem_nxt[DigitW-1:0];
    end
  end

  // Load the output register with the sign or the next digit symbol
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= SignChar;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= top_sym;
      last_q <= (nd_q == StackCntW'(1));
    end
  end

  assign sts_o.quot_zero  = (quo_nxt == '0);
  assign sts_o.stack_fill = (nd_q == StackCntW'(StackDepth - 1));
  assign sts_o.last_digit = (nd_q == StackCntW'(1));
  assign sts_o.neg        = neg_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// File: sv/sird_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences division, sign and digit output for one item.
module sird_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           alpha_ok_i,
  input  sird_pkg::sts_t sts_i,
  output sird_pkg::cmd_t cmd_o
);
  import sird_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StSign,
    StEmit
  } state_e;

  state_e              state_q, state_d;
  logic [DivStepW-1:0] step_q, step_d;
  logic                last_step;

  assign last_step  = (step_q == DivStepW'(DivSteps - 1));
  assign in_ready_o = (state_q == StIdle);

  // Decode commands and the next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        // Drop the item when the alphabet is invalid
        if (in_valid_i && alpha_ok_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (last_step) begin
          cmd_o.push = 1'b1;
          step_d     = '0;
          if (sts_i.quot_zero || sts_i.stack_fill) begin
            state_d = sts_i.neg ? StSign : StEmit;
          end
        end else begin
          step_d = step_q + DivStepW'(1);
        end
      end
      StSign: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.last_digit) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state and divider step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: sv/signed_integer_to_radix_digits.sv
`timescale 1ns / 1ps
// Signed 32-bit number to text in a configured radix: user-facing top level.
//
// Each number item is turned into its text in the base set by the configured
// alphabet (2 to 16 distinct symbols, none zero, '+' or '-'), most
// significant digit first, with '-' ahead of a negative value and last set on
// the final character. With an invalid alphabet the item is taken and nothing
// comes out. A shared divider resolves 8 quotient bits per cycle and yields
// one digit per full division of the magnitude; the digits are stacked, then
// the characters (sign included) go out as the output side takes them. A new
// item is taken once the last character of the previous one is in the output
// register.
module signed_integer_to_radix_digits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [sird_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sird_pkg::SymRegW-1:0]  cfg_data_i,
  // Number items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [sird_pkg::NumW-1:0] number_i,
  // Character items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sird_pkg::SymW-1:0]     character_o,
  output logic                          last_o
);
  import sird_pkg::*;

  logic [LenW-1:0]    len_q;
  logic [SymRegW-1:0] sym_lo_q;
  logic [SymRegW-1:0] sym_hi_q;
  logic               alpha_ok;
  cmd_t               cmd;
  sts_t               sts;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgAlphabetLength) begin
        len_q <= cfg_data_i[LenW-1:0];
      end
      if (cfg_idx_i == CfgSymbolsLow) begin
        sym_lo_q <= cfg_data_i;
      end
      if (cfg_idx_i == CfgSymbolsHigh) begin
        sym_hi_q <= cfg_data_i;
      end
    end
  end

  sird_alpha u_alpha (
    .len_i     (len_q),
    .symbols_i ({sym_hi_q, sym_lo_q}),
    .ok_o      (alpha_ok)
  );

  sird_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .alpha_ok_i (alpha_ok),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sird_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (number_i),
    .base_i      (len_q),
    .symbols_i   ({sym_hi_q, sym_lo_q}),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// File: test/sird_checker.sv
`timescale 1ns / 1ps
// Checker for the radix digit converter: predicts each number's text and compares it.
module sird_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sird_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sird_pkg::SymRegW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [sird_pkg::NumW-1:0]    number_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [sird_pkg::SymW-1:0]    character_i,
  input  logic                         last_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import sird_pkg::*;

  typedef struct packed {
    logic [SymW-1:0] character;
    logic            last;
  } text_char_t;

  // Shadow copy of the configuration registers
  logic [LenW-1:0]    alpha_len;
  logic [SymRegW-1:0] sym_lo;
  logic [SymRegW-1:0] sym_hi;

  // Characters still owed by the block, oldest first
  text_char_t text_q[$];
  int         errors;

  function automatic logic [SymW-1:0] symbol_of(input int unsigned idx);
    if (idx < 8) return sym_lo[8*idx +: 8];
    return sym_hi[8*(idx-8) +: 8];
  endfunction

  // Base of the current alphabet, or zero when the alphabet is unusable
  function automatic int unsigned alphabet_base();
    int unsigned len;
    logic [SymW-1:0] s;
    len = alpha_len;
    if (len < 2 || len > MaxBase) return 0;
    for (int unsigned i = 0; i < len; i++) begin
      s = symbol_of(i);
      if (s == 8'h00 || s == PlusChar || s == SignChar) return 0;
      for (int unsigned j = i + 1; j < len; j++) begin
        if (symbol_of(j) == s) return 0;
      end
    end
    return len;
  endfunction

  // Queue the text of one number: sign, then digits most significant first
  function automatic void predict_text(input logic [NumW-1:0] num);
    int unsigned     base;
    logic [NumW-1:0] mag;
    logic [DigitW-1:0] digits [NumW];
    int              nd;
    text_char_t      c;
    base = alphabet_base();
    if (base == 0) return;
    mag = num[NumW-1] ? -num : num;
    nd = 0;
    do begin
      digits[nd] = DigitW'(mag % base);
      mag = mag / base;
      nd++;
    end while (mag != 0 && nd < NumW);
    if (num[NumW-1]) begin
      c.character = SignChar;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.character = symbol_of(digits[k]);
      c.last = (k == 0);
      text_q.push_back(c);
    end
  endfunction

  // Compare outgoing characters, predict from incoming numbers, track writes
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t exp_char;
    if (!rst_ni) begin
      alpha_len = '0;
      sym_lo = '0;
      sym_hi = '0;
      text_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (text_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected character: expected none, got %h last %b",
                   $time, character_i, last_i);
        end else begin
          exp_char = text_q.pop_front();
          if (character_i !== exp_char.character) begin
            errors++;
            $display("%0t: character mismatch: expected %h, got %h",
                     $time, exp_char.character, character_i);
          end
          if (last_i !== exp_char.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, got %b",
                     $time, exp_char.last, last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_text(number_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgAlphabetLength: alpha_len = cfg_data_i[LenW-1:0];
          CfgSymbolsLow:     sym_lo = cfg_data_i;
          CfgSymbolsHigh:    sym_hi = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= errors;
      pending_o <= text_q.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the radix digit converter: stimulus, flow control and verdict.
module tb;
  import sird_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned RandomItems   = 410;
  localparam int unsigned HoldOffCycles = 400;
  localparam logic [CfgIdxW-1:0] CfgNoRegister = 2'd3;

  typedef enum {FaultShort, FaultLong, FaultBadSymbol, FaultRepeat} alphabet_fault_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [SymRegW-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [NumW-1:0]    number = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SymW-1:0]    character;
  logic               last;
  int                 fail_count;
  int                 pending;

  int unsigned sender_idle_pct = 17;
  int unsigned receiver_idle_pct = 53;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  signed_integer_to_radix_digits dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .number_i    (number),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .character_o (character),
    .last_o      (last)
  );

  sird_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .number_i     (number),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .character_i  (character),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk = ~clk;

  // Receiver: random back-pressure, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HoldOffCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: cycle limit reached", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Leaves the write enable high; end_writes drops it
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [SymRegW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_alphabet(input logic [LenW-1:0] len, input logic [SymRegW-1:0] lo,
                              input logic [SymRegW-1:0] hi);
    logic [SymRegW-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LenW-1:0] = len;
    write_register(CfgAlphabetLength, len_word);
    write_register(CfgSymbolsLow, lo);
    write_register(CfgSymbolsHigh, hi);
    end_writes();
  endtask

  // Offer one number, with a random gap first; valid stays high on return
  task automatic offer_number(input logic [NumW-1:0] value);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    number <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the input until every owed character is out
  task automatic wait_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Idle the block completely so registers may be rewritten
  task automatic wait_drained();
    wait_empty();
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Distinct legal symbols, random bytes beyond the length, optionally one fault
  function automatic void random_alphabet(input bit broken, output logic [LenW-1:0] len,
                                          output logic [SymRegW-1:0] lo,
                                          output logic [SymRegW-1:0] hi);
    logic [SymW-1:0] sym [SymCount];
    bit              taken [256];
    int unsigned     n;
    int unsigned     pos;
    logic [SymW-1:0] b;
    alphabet_fault_e fault;
    if ($urandom_range(3) == 0) n = $urandom_range(1) ? 2 : SymCount;
    else n = $urandom_range(SymCount, 2);
    for (int i = 0; i < SymCount; i++) sym[i] = SymW'($urandom);
    for (int i = 0; i < n; i++) begin
      do b = SymW'($urandom_range(255, 1));
      while (taken[b] || b == PlusChar || b == SignChar);
      taken[b] = 1'b1;
      sym[i] = b;
    end
    if (broken) begin
      fault = alphabet_fault_e'($urandom_range(3));
      case (fault)
        FaultShort: n = $urandom_range(1);
        FaultLong:  n = $urandom_range(31, 17);
        FaultBadSymbol: begin
          pos = $urandom_range(n - 1);
          case ($urandom_range(2))
            0:       sym[pos] = 8'h00;
            1:       sym[pos] = PlusChar;
            default: sym[pos] = SignChar;
          endcase
        end
        FaultRepeat: begin
          pos = $urandom_range(n - 1, 1);
          sym[pos] = sym[$urandom_range(pos - 1)];
        end
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = sym[i];
      hi[8*i +: 8] = sym[i+8];
    end
    len = LenW'(n);
  endfunction

  // Extremes, values near powers of the base, small values and full-range ones
  function automatic logic [NumW-1:0] random_number(input int unsigned base);
    logic [63:0]     p;
    logic [NumW-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      1, 2: begin
        p = 64'd1;
        repeat ($urandom_range(31, 1)) begin
          if (p * base <= 64'hFFFF_FFFF) p = p * base;
        end
        v = p[NumW-1:0] + NumW'($urandom_range(2)) - 1;
        if ($urandom_range(1)) v = -v;
      end
      3, 4, 5: begin
        v = NumW'($urandom_range(300));
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    logic [LenW-1:0]    len;
    logic [SymRegW-1:0] lo;
    logic [SymRegW-1:0] hi;
    bit                 broken;
    bit                 paused;
    int unsigned        count;
    int unsigned        base;
    int unsigned        done_items;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Alphabet is unusable straight after reset
    offer_number(32'd5);
    wait_drained();

    // Length ten, but symbols 8 and 9 are zero bytes, so the alphabet is unusable
    set_alphabet(5'd10, 64'h3736_3534_3332_3130, 64'h2D2B_00FF_2D2B_0000);
    offer_number(32'd0);
    offer_number(32'd1);
    offer_number(32'hFFFF_FFFF);
    offer_number(32'h7FFF_FFFF);
    offer_number(32'h8000_0000);
    offer_number(32'd10);
    offer_number(-32'sd9);
    wait_drained();

    // Write to the unused register index: the alphabet must survive
    write_register(CfgNoRegister, '1);
    end_writes();
    offer_number(32'd1_000_000_000);
    wait_drained();

    // Full sixteen-symbol alphabet
    set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    offer_number(32'h8000_0000);
    offer_number(32'hFFFF_FFFF);
    offer_number(32'hDEAD_BEEF);
    wait_drained();

    // Binary, the longest text
    set_alphabet(5'd2, 64'h2D2B_0000_0000_3130, 64'h0);
    offer_number(32'h8000_0000);
    offer_number(32'hFFFF_FFFF);
    offer_number(32'h7FFF_FFFF);
    wait_drained();

    // Unusable alphabets: short, overlong, bad symbols, repeated symbol
    set_alphabet(5'd1, 64'h3736_3534_3332_3130, 64'h0);
    offer_number(32'd77);
    wait_drained();
    set_alphabet(5'd17, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    offer_number(32'hFFFF_FFFF);
    wait_drained();
    set_alphabet(5'd31, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    offer_number(32'd12345);
    wait_drained();
    set_alphabet(5'd10, 64'h3736_3534_0032_3130, 64'h0);
    offer_number(32'd999);
    wait_drained();
    set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h2B65_6463_6261_3938);
    offer_number(32'h8000_0000);
    wait_drained();
    set_alphabet(5'd10, 64'h3736_3534_3332_312D, 64'h0);
    offer_number(-32'sd1);
    wait_drained();
    set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h3065_6463_6261_3938);
    offer_number(32'd255);
    wait_drained();

    // Random alphabets and numbers through three flow-control regimes
    done_items = 0;
    paused = 1'b0;
    hold_requests = hold_requests + 1;
    while (done_items < RandomItems) begin
      if (done_items < RandomItems / 3) begin
        sender_idle_pct = 17;
        receiver_idle_pct = 53;
      end else if (done_items < 2 * RandomItems / 3) begin
        sender_idle_pct = 53;
        receiver_idle_pct = 17;
      end else begin
        if (sender_idle_pct != 0) hold_requests = hold_requests + 1;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      broken = ($urandom_range(4) == 0);
      random_alphabet(broken, len, lo, hi);
      set_alphabet(len, lo, hi);
      base = broken ? 10 : len;
      count = broken ? $urandom_range(4, 2) : $urandom_range(30, 8);
      for (int unsigned k = 0; k < count; k++) begin
        if (!broken && !paused && done_items >= RandomItems / 2 && k == count / 2) begin
          wait_empty();
          paused = 1'b1;
        end
        offer_number(random_number(base));
      end
      if (!broken) done_items = done_items + count;
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sird_pkg.sv
sv/sird_alpha.sv
sv/sird_dp.sv
sv/sird_ctrl.sv
sv/signed_integer_to_radix_digits.sv
test/sird_checker.sv
test/tb.sv
